FILE: src/dq_pkg.sv
// Shared types, widths and opcode/status codes for the double-ended queue.
// No dependencies; compile first.
package dq_pkg;

    localparam int DATA_W        = 16;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;
    localparam int DEFAULT_DEPTH = 16;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_opcode;
    typedef logic [ST_W-1:0]          t_status;

    localparam t_opcode OP_PUSH_BACK  = 2'd0;
    localparam t_opcode OP_PUSH_FRONT = 2'd1;
    localparam t_opcode OP_POP_BACK   = 2'd2;
    localparam t_opcode OP_POP_FRONT  = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Per-cell control: shift toward the back, shift toward the front, load the input word.
    typedef struct packed {
        logic shift_back;
        logic shift_front;
        logic load;
    } t_cell_ctl;

endpackage

FILE: src/dq_if.sv
// Valid/ready channel interfaces for operations in and results out.
// Depends on dq_pkg.
interface dq_op_if;
    logic             valid;
    logic             ready;
    dq_pkg::t_opcode  opcode;
    dq_pkg::t_word    data_in;

    modport source (output valid, output opcode, output data_in, input ready);
    modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface dq_res_if #(
    parameter int CNT_W = 5
);
    logic             valid;
    logic             ready;
    dq_pkg::t_word    data_out;
    dq_pkg::t_status  status;
    logic [CNT_W-1:0] item_count;
    logic             is_empty;

    modport source (output valid, output data_out, output status, output item_count,
                    output is_empty, input ready);
    modport sink   (input valid, input data_out, input status, input item_count,
                    input is_empty, output ready);
endinterface

FILE: src/double_ended_queue.sv
// Top level of the bounded double-ended queue built as a row of shifting cells.
// Depends on dq_pkg, dq_if and dq_row.
//
// Usage:
//   i_op  (sink)  : one word per operation: opcode and data_in.
//                   opcode: push back, push front, pop back, pop front.
//   o_res (source): one word per operation: data_out (popped value, zero
//                   otherwise), status (ok, pop on empty, push on full),
//                   item_count after the operation and is_empty.
// Result: the result word is registered; it appears in the cycle after its operation is accepted.
// Throughput: one operation per cycle while o_res.ready is high. The whole
//   operation (count compare, at most one shift or load in the cell row, read
//   of the front or back cell) is combinational and lands in the result register.
// Storage: cell 0 always holds the front value; a push or pop at the front
//   shifts the whole row by one cell; a push at the back loads the cell selected
//   by the count, and a pop at the back reads the back cell without a shift.
// Reset: i_rst_n is synchronous, active low; it empties the queue and drops
//   any pending result. Cell contents are not cleared.
// Stall: while a result word waits and o_res.ready is low, i_op.ready is low
//   and the result register holds its word.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_op_if.sink    i_op,
    dq_res_if.source o_res
);
    import dq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_word            r_data_out;
    t_word            n_data_out;
    t_status          r_status;
    t_status          n_status;

    logic  w_accept;
    logic  w_full;
    logic  w_empty;
    logic  w_shift_back;
    logic  w_shift_front;
    logic  w_push_back;
    t_word w_front;
    t_word w_back;

    // Take a new word whenever the result register is free or being drained.
    assign i_op.ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_op.valid && i_op.ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_push_back   = w_accept && (i_op.opcode == OP_PUSH_BACK)  && !w_full;
    assign w_shift_back  = w_accept && (i_op.opcode == OP_PUSH_FRONT) && !w_full;
    assign w_shift_front = w_accept && (i_op.opcode == OP_POP_FRONT)  && !w_empty;

    dq_row #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_row (
        .i_clk         (i_clk),
        .i_shift_back  (w_shift_back),
        .i_shift_front (w_shift_front),
        .i_push_back   (w_push_back),
        .i_count       (r_count),
        .i_din         (i_op.data_in),
        .o_front       (w_front),
        .o_back        (w_back)
    );

    // Decode the operation against the current fill level.
    always_comb begin
        n_count    = r_count;
        n_data_out = '0;
        n_status   = ST_OK;
        unique case (i_op.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data_out = w_back;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data_out = w_front;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Control state: fill count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_out <= n_data_out;
            r_status   <= n_status;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.data_out   = r_data_out;
    assign o_res.status     = r_status;
    assign o_res.item_count = r_count;
    assign o_res.is_empty   = w_empty;

endmodule

FILE: src/dq_cell.sv
// One storage cell of the queue row; takes a word from either neighbor or the input.
// Depends on dq_pkg.
module dq_cell (
    input  logic              i_clk,
    input  dq_pkg::t_cell_ctl i_ctl,
    input  logic              i_is_back,
    input  dq_pkg::t_word     i_prev,
    input  dq_pkg::t_word     i_next,
    input  dq_pkg::t_word     i_din,
    output dq_pkg::t_word     o_data,
    output dq_pkg::t_word     o_tap
);
    import dq_pkg::*;

    t_word r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_back) begin
            r_data <= i_prev;
        end else if (i_ctl.shift_front) begin
            r_data <= i_next;
        end else if (i_ctl.load) begin
            r_data <= i_din;
        end
    end

    assign o_data = r_data;
    assign o_tap  = i_is_back ? r_data : '0;

endmodule

FILE: src/dq_row.sv
// Row of DEPTH cells; cell 0 holds the front word, cell count-1 the back word.
// Depends on dq_pkg and dq_cell.
module dq_row #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_shift_back,
    input  logic             i_shift_front,
    input  logic             i_push_back,
    input  logic [CNT_W-1:0] i_count,
    input  dq_pkg::t_word    i_din,
    output dq_pkg::t_word    o_front,
    output dq_pkg::t_word    o_back
);
    import dq_pkg::*;

    t_word w_data [DEPTH];
    t_word w_tap  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_word     w_prev;
        t_word     w_next;
        logic      w_is_back;

        assign w_ctl.shift_back  = i_shift_back;
        assign w_ctl.shift_front = i_shift_front;
        assign w_ctl.load        = i_push_back && (i_count == CNT_W'(g));
        assign w_is_back         = (i_count == CNT_W'(g + 1));

        if (g == 0) begin : g_head
            assign w_prev = i_din;
        end else begin : g_body
            assign w_prev = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_data[g];
        end else begin : g_inner
            assign w_next = w_data[g+1];
        end

        dq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_is_back (w_is_back),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_din     (i_din),
            .o_data    (w_data[g]),
            .o_tap     (w_tap[g])
        );
    end

    // Only the back cell drives a nonzero tap, so an OR collects it.
    always_comb begin
        o_back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_back = o_back | w_tap[k];
        end
    end

    assign o_front = w_data[0];

endmodule
